>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is held
`define KST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define KST_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/kst_pkg.sv
// ---------------------------------------------------------------------------
// kst_pkg
// shared constants, codes and types of the key slot table engine
// ---------------------------------------------------------------------------
package kst_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);

  localparam logic [31:0] RETAIN_TYPE = 32'h0000_0031;
  localparam logic [3:0]  COUNT_MAX   = 4'd15;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_FREE   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] sys;
    logic [31:0] key;
    logic [31:0] typ;
  } entry_t;

  typedef struct packed {
    logic sys_eq;
    logic key_eq;
    logic type_eq;
    logic is_free;
  } match_t;

endpackage

>>> hdl/kst_match.sv
// ---------------------------------------------------------------------------
// kst_match
// shared compare unit: one table entry against the request fields
// ---------------------------------------------------------------------------
module kst_match (
  input  kst_pkg::entry_t ent,
  input  logic [31:0]     sys,
  input  logic [31:0]     key,
  input  logic [31:0]     typ,
  output kst_pkg::match_t m
);

  always_comb begin
    m.sys_eq  = (ent.sys == sys);
    m.key_eq  = (ent.key == key);
    m.type_eq = (ent.typ == typ);
    m.is_free = (ent.typ == 32'd0);
  end

endmodule

>>> hdl/key_slot_table_engine_core.sv
// ---------------------------------------------------------------------------
// key_slot_table_engine_core
// key slot table with write, lookup, free search and remove-except-one
//
//   channel  dir  tdata                                   tuser
//   in_      in   slot, sys_id, key_id, key_class          req_type
//   out_     out  result_index, removed_count              -
//
// write, and lookup with key type zero: no scan, straight from idle to the finish state
// lookup and free search: scan from slot 1 to the first hit or to slot SLOTS-1
// remove: one scan to find the kept key, then, if it is found, a clearing scan of
//   slots 1 to SLOTS-1; one slot per cycle through the compare unit
// reset clears the whole table at once; in_tready is low while a request runs
// a finished result waits in the output register while the next one is taken
// ---------------------------------------------------------------------------
module key_slot_table_engine_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // slot, sys_id, key_id, key_class, zero pad
  input  logic [1:0]   in_tuser,  // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata  // result_index, removed_count
);

  localparam int IW = kst_pkg::IDX_W;

  kst_pkg::state_t state_r, state_nxt;
  kst_pkg::req_t   req_r, req_nxt;
  logic [31:0]     sys_r, sys_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [31:0]     typ_r, typ_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   hit_r, hit_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [3:0]      out_idx_r, out_idx_nxt;
  logic [3:0]      out_cnt_r, out_cnt_nxt;

  kst_pkg::entry_t table_r [kst_pkg::SLOTS];
  kst_pkg::entry_t cur_ent;
  kst_pkg::match_t m;

  logic            we;
  logic [IW-1:0]   wa;
  kst_pkg::entry_t wd;

  logic [3:0]      in_slot;
  logic [31:0]     in_sys;
  logic [31:0]     in_key;
  logic [31:0]     in_type;
  logic            last;
  logic            find_hit;

  assign in_slot = in_tdata[3:0];
  assign in_sys  = in_tdata[35:4];
  assign in_key  = in_tdata[67:36];
  assign in_type = in_tdata[99:68];

  assign cur_ent = table_r[idx_r];
  assign last    = (idx_r == IW'(kst_pkg::SLOTS - 1));

  kst_match u_match (
    .ent (cur_ent),
    .sys (sys_r),
    .key (key_r),
    .typ (typ_r),
    .m   (m)
  );

  assign find_hit = (req_r == kst_pkg::REQ_FREE) ? m.is_free
                                                 : (m.sys_eq && m.key_eq && m.type_eq);

  assign in_tready  = (state_r == kst_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_idx_r};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    sys_nxt       = sys_r;
    key_nxt       = key_r;
    typ_nxt       = typ_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    we            = 1'b0;
    wa            = idx_r;
    wd            = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      kst_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt = kst_pkg::req_t'(in_tuser);
          sys_nxt = in_sys;
          key_nxt = in_key;
          typ_nxt = (in_tuser == kst_pkg::REQ_REMOVE) ? kst_pkg::RETAIN_TYPE : in_type;
          idx_nxt = IW'(1);
          hit_nxt = '0;
          cnt_nxt = '0;
          case (kst_pkg::req_t'(in_tuser))
            kst_pkg::REQ_WRITE: begin
              if (in_slot != 4'd0 && 32'(in_slot) < kst_pkg::SLOTS) begin
                we      = 1'b1;
                wa      = IW'(in_slot);
                wd      = '{sys: in_sys, key: in_key, typ: in_type};
                hit_nxt = IW'(in_slot);
              end
              state_nxt = kst_pkg::ST_FINISH;
            end
            kst_pkg::REQ_LOOKUP: begin
              state_nxt = (in_type == 32'd0) ? kst_pkg::ST_FINISH : kst_pkg::ST_FIND;
            end
            default: begin
              state_nxt = kst_pkg::ST_FIND;
            end
          endcase
        end
      end
      kst_pkg::ST_FIND: begin
        if (find_hit) begin
          hit_nxt = idx_r;
          if (req_r == kst_pkg::REQ_REMOVE) begin
            cnt_nxt   = 4'd1;
            idx_nxt   = IW'(1);
            state_nxt = kst_pkg::ST_CLEAR;
          end else begin
            state_nxt = kst_pkg::ST_FINISH;
          end
        end else if (last) begin
          state_nxt = kst_pkg::ST_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      kst_pkg::ST_CLEAR: begin
        if (idx_r != hit_r && m.sys_eq) begin
          we = 1'b1;
          wa = idx_r;
          wd = '0;
          if (cnt_r != kst_pkg::COUNT_MAX) begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
        if (last) begin
          state_nxt = kst_pkg::ST_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      kst_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 4'(hit_r);
          out_cnt_nxt   = cnt_r;
          state_nxt     = kst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kst_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    sys_r     <= sys_nxt;
    key_r     <= key_nxt;
    typ_r     <= typ_nxt;
    idx_r     <= idx_nxt;
    hit_r     <= hit_nxt;
    cnt_r     <= cnt_nxt;
    out_idx_r <= out_idx_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // table storage, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kst_pkg::SLOTS; i++) begin
        table_r[i] <= '0;
      end
    end else if (we) begin
      table_r[wa] <= wd;
    end
  end

endmodule

>>> hdl/kst_checker.sv
// ---------------------------------------------------------------------------
// kst_checker
// port-level checks on the key slot table engine, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  logic       in_req_seen;
  logic       out_stall;
  logic [3:0] out_idx;
  logic [3:0] out_cnt;

  assign in_req_seen = in_tvalid && in_tready;
  assign out_stall   = out_tvalid && !out_tready;
  assign out_idx     = out_tdata[3:0];
  assign out_cnt     = out_tdata[7:4];

  `KST_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid && $stable(out_tdata), "held result changed")
  `KST_ASSERT(a_busy_after_req, clk, rst_n, in_req_seen |=> !in_tready, "ready after a request")
  `KST_ASSERT(a_count_has_index, clk, rst_n, out_tvalid && out_cnt != 4'd0 |-> out_idx != 4'd0, "count without slot")
  `KST_ASSERT(a_result_from_busy, clk, rst_n, $rose(out_tvalid) |-> !$past(in_tready), "result while idle")

endmodule

bind key_slot_table_engine_core kst_checker u_kst_checker (.*);
